>>> rtl/afr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_pkg
// shared types and codes for the api frame receiver
// ----------------------------------------------------------------------------
package afr_pkg;

    // frame phase codes
    localparam logic [2:0] PH_WAIT    = 3'd0;
    localparam logic [2:0] PH_LEN_HI  = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;

    // event codes carried on m_tuser
    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_BYTE  = 3'd1;
    localparam logic [2:0] EV_GOOD  = 3'd2;
    localparam logic [2:0] EV_BAD   = 3'd3;
    localparam logic [2:0] EV_ABORT = 3'd4;

    localparam logic [7:0] GOOD_SUM = 8'hFF;

    // register indexes
    localparam logic REG_START_DELIM = 1'b0;
    localparam logic REG_MAX_LENGTH  = 1'b1;

    localparam logic [7:0]  START_DELIM_RESET = 8'h7E;
    localparam logic [15:0] MAX_LENGTH_RESET  = 16'd128;

    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] length;
        logic [15:0] byte_count;
        logic [7:0]  running_sum;
    } afr_state_t;

    typedef struct packed {
        logic [7:0]  start_delimiter;
        logic [15:0] max_length;
    } afr_cfg_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [15:0] frame_length;
    } afr_result_t;

endpackage
`default_nettype wire

>>> rtl/afr_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_step
// per-byte frame tracking: next state and result for one received byte
// ----------------------------------------------------------------------------
module afr_step
    import afr_pkg::*;
(
    input  wire afr_state_t  cur_state,
    input  wire afr_cfg_t    cfg,
    input  wire [7:0]        rx_byte,
    output afr_state_t       nxt_state,
    output afr_result_t      result
);

    logic [2:0]  ph;
    logic [15:0] full_len;
    logic [15:0] count_inc;
    logic [7:0]  sum_inc;

    assign ph        = (cur_state.phase <= PH_CHECK) ? cur_state.phase : PH_WAIT;
    assign full_len  = {cur_state.length[15:8], rx_byte};
    assign count_inc = cur_state.byte_count + 16'd1;
    assign sum_inc   = cur_state.running_sum + rx_byte;

    always_comb begin
        nxt_state = cur_state;
        result    = '0;
        if (ph != PH_WAIT && rx_byte == cfg.start_delimiter) begin
            // delimiter inside a frame: abort and reopen
            result.event_res    = EV_ABORT;
            result.frame_length = cur_state.length;
            nxt_state           = '0;
            nxt_state.phase     = PH_LEN_HI;
        end else begin
            case (ph)
                PH_LEN_HI: begin
                    nxt_state.length = {rx_byte, 8'h00};
                    nxt_state.phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    nxt_state.length = (full_len > cfg.max_length) ? cfg.max_length
                                                                   : full_len;
                    nxt_state.phase  = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    result.event_res     = EV_BYTE;
                    result.payload_byte  = rx_byte;
                    result.payload_index = cur_state.byte_count;
                    result.frame_length  = cur_state.length;
                    nxt_state.byte_count = count_inc;
                    nxt_state.running_sum = sum_inc;
                    // zero length still takes one byte (counter wrap also ends it)
                    if (count_inc >= cur_state.length || count_inc == 16'd0) begin
                        nxt_state.phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    nxt_state.running_sum = sum_inc;
                    result.event_res      = (sum_inc == GOOD_SUM) ? EV_GOOD : EV_BAD;
                    result.frame_length   = cur_state.length;
                    nxt_state.phase       = PH_WAIT;
                end
                default: begin
                    nxt_state.phase = PH_WAIT;
                    if (rx_byte == cfg.start_delimiter) begin
                        nxt_state       = '0;
                        nxt_state.phase = PH_LEN_HI;
                    end
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/api_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// api_frame_receiver
// serial api frame tracker: delimiter, length, payload and checksum
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one received serial byte per beat in s_tdata[7:0]
//   m_ channel: exactly one result beat for every input beat, in order;
//     m_tuser carries the event code (none, payload byte, frame good,
//     checksum bad, frame aborted), m_tdata the payload byte, its index and
//     the clamped frame length
//   apb port: start delimiter at 0x0, max length at 0x4, pready tied high;
//     write only while the stream is idle
//   timing: the result beat is registered and presented in the cycle after its input beat
//   throughput: one byte per cycle while the result stream does not stall;
//     the frame state and the result register are both updated at the
//     accepting edge by a single pass of add, compare and select logic
//   stall: s_tready follows the output register; while a result waits and
//     m_tready is low no new byte is taken, and a waiting result is replaced
//     in the same cycle it is taken
//   reset: synchronous active-low aresetn clears the frame state to waiting
//     for start, empties the output register and restores the registers to
//     delimiter 0x7E and max length 128
// ----------------------------------------------------------------------------
module api_frame_receiver
    import afr_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,

    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [7:0]   s_tdata,     // [7:0] rx_byte

    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,     // [7:0] payload_byte, [23:8] payload_index,
                                     // [39:24] frame_length
    output logic [2:0]  m_tuser,     // [2:0] event_res

    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    afr_state_t  state_reg;
    afr_state_t  state_next;
    afr_cfg_t    cfg_reg;
    afr_result_t result_next;
    afr_result_t result_reg;
    logic        valid_reg;
    logic        in_beat;
    logic        cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign in_beat  = s_tvalid && s_tready;

    // room when the output register is empty or being emptied this cycle
    assign s_tready = !valid_reg || m_tready;

    // register file, word aligned; paddr[2] selects the register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_delimiter <= START_DELIM_RESET;
            cfg_reg.max_length      <= MAX_LENGTH_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_START_DELIM: cfg_reg.start_delimiter <= pwdata[7:0];
                REG_MAX_LENGTH:  cfg_reg.max_length      <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_START_DELIM: prdata = {24'd0, cfg_reg.start_delimiter};
            REG_MAX_LENGTH:  prdata = {16'd0, cfg_reg.max_length};
            default:         prdata = 32'd0;
        endcase
    end

    // per-byte frame logic
    afr_step u_step (
        .cur_state (state_reg),
        .cfg       (cfg_reg),
        .rx_byte   (s_tdata),
        .nxt_state (state_next),
        .result    (result_next)
    );

    // frame state advances on every accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (in_beat) begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_beat) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = result_reg.event_res;
    assign m_tdata  = {result_reg.frame_length, result_reg.payload_index,
                       result_reg.payload_byte};

endmodule
`default_nettype wire

>>> rtl/afr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afr_checker
// port-level checks on the result stream of the api frame receiver
// ----------------------------------------------------------------------------
module afr_checker
    import afr_pkg::*;
(
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [39:0] m_tdata,
    input wire [2:0]  m_tuser
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // every accepted byte yields a result beat next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted byte produced no result");

    // payload fields are zero unless the event is a payload byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != EV_BYTE |-> m_tdata[23:0] == 24'd0)
        else $error("payload fields set on non-byte event");

    // no frame length on an empty event, and no code above abort
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= EV_ABORT && (m_tuser != EV_NONE || m_tdata[39:24] == 16'd0))
        else $error("bad event code or length on empty event");

    // reset empties the output register
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind api_frame_receiver afr_checker u_afr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
